// ===== rtl/ita_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character functions for the integer to ASCII converter.
package ita_pkg;

  // Command carried in tuser with each input word.
  typedef enum logic [1:0] {
    CMD_SIGNED = 2'd0,
    CMD_HEX    = 2'd1,
    CMD_PTR    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RADIX       = 2'd0,
    CFG_DIGITS_LOW  = 2'd1,
    CFG_DIGITS_HIGH = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_e;

  localparam int unsigned RadixW   = 5;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned CharW    = 8;
  localparam int unsigned CfgDataW = 64;

  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;
  localparam logic [RadixW-1:0] HexRadix   = 5'd16;

  // Quotient bits resolved by the divider per clock.
  localparam int unsigned DivStep = 8;

  localparam logic [CharW-1:0] CharZero     = 8'd48;
  localparam logic [CharW-1:0] CharX        = 8'd120;
  localparam logic [CharW-1:0] CharMinus    = 8'd45;
  localparam logic [CharW-1:0] HexAlphaBase = 8'd87;

  // Character for a digit taken from the programmed digit table.
  function automatic logic [CharW-1:0] table_char(input logic [DigitW-1:0] d,
                                                   input logic [63:0] lo,
                                                   input logic [63:0] hi);
    logic [63:0] word;
    word = d[3] ? hi : lo;
    return word[{d[2:0], 3'b000} +: CharW];
  endfunction

  // Lowercase hexadecimal character for a digit.
  function automatic logic [CharW-1:0] hex_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] ext;
    ext = {{(CharW-DigitW){1'b0}}, d};
    return (d < 4'd10) ? (CharZero + ext) : (HexAlphaBase + ext);
  endfunction

endpackage

// ===== rtl/ita_div.sv =====
`timescale 1ns / 1ps
// Iterative divider of a wide value by a small radix, several quotient bits per clock.
module ita_div #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [VALUE_BITS-1:0]             dividend_i,
  input  logic [ita_pkg::RadixW-1:0]        divisor_i,
  output logic                              done_o,
  output logic [VALUE_BITS-1:0]             quotient_o,
  output logic [ita_pkg::DigitW-1:0]        remainder_o
);

  localparam int unsigned Step  = ita_pkg::DivStep;
  localparam int unsigned Steps = (VALUE_BITS + Step - 1) / Step;
  localparam int unsigned PadW  = Steps * Step;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [PadW-1:0]             work_q, work_d;
  logic [ita_pkg::DigitW-1:0]  rem_q, rem_d;

  // Restoring division: each step shifts one dividend bit into the
  // remainder and subtracts the divisor when it fits.
  always_comb begin
    logic [ita_pkg::RadixW-1:0] t;
    logic [PadW-1:0]            w;
    logic [ita_pkg::DigitW-1:0] r;
    w = work_q;
    r = rem_q;
    for (int k = 0; k < Step; k++) begin
      t = {r, w[PadW-1]};
      w = {w[PadW-2:0], 1'b0};
      if (t >= divisor_i) begin
        t    = t - divisor_i;
        w[0] = 1'b1;
      end
      r = t[ita_pkg::DigitW-1:0];
    end
    work_d = w;
    rem_d  = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(Steps);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CntW'(1);
      busy_q <= (cnt_q != CntW'(1));
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      work_q <= PadW'(dividend_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// Top level of the integer to ASCII converter: sequencer, digit store and output register.
//
// Each input word carries a 64-bit value in tdata and a command in tuser. Command 0
// writes the low VALUE_BITS bits as a signed number in the programmed radix (2 to 16,
// values outside are clamped) using the programmed digit table, with a leading minus
// sign; the most negative value is written as that value plus one. Command 1 writes
// the bits as unsigned lowercase hex, command 2 writes "0x" and then that hex, and
// command 3 is dropped without output. Characters leave one per output word, most
// significant digit first, with tlast on the final one. The block works on one value
// at a time and holds s_axis_tready low until the value's last character has been
// loaded into the output register. Digits are produced by one shared divider that
// resolves 8 quotient bits per clock and are kept in a 4-bit wide digit memory. The
// digits are then read back through the read and emit states, after any prefix
// characters, and the output side may stall each character. Configuration writes are
// taken whenever cfg_we_i is high and must only be made while the block is idle.
module integer_to_ascii_radix #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [ita_pkg::CfgDataW-1:0]       cfg_data_i,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,   // [63:0] value
  input  logic [1:0]                         s_axis_tuser,   // [1:0] cmd
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ita_pkg::CharW-1:0]          m_axis_tdata,   // [7:0] char_out
  output logic                               m_axis_tlast    // last
);

  localparam int unsigned Depth = VALUE_BITS;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIVIDE = 5'b00010,
    ST_PREFIX = 5'b00100,
    ST_READ   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  // Configuration registers.
  logic [ita_pkg::RadixW-1:0] radix_q;
  logic [63:0]                digits_lo_q;
  logic [63:0]                digits_hi_q;

  // Sequencer state.
  state_e                     state_q, state_d;
  logic [VALUE_BITS-1:0]      remaining_q, remaining_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [IdxW-1:0]            ptr_q, ptr_d;
  logic [1:0]                 pre_q, pre_d;
  logic                       neg_q, neg_d;
  ita_pkg::cmd_e              cmd_q, cmd_d;
  logic [ita_pkg::RadixW-1:0] base_q, base_d;
  logic                       div_start_q, div_start_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [ita_pkg::CharW-1:0]  out_char_q, out_char_d;
  logic                       out_last_q, out_last_d;

  // Digit memory.
  logic [ita_pkg::DigitW-1:0] digit_mem_q [Depth];
  logic [ita_pkg::DigitW-1:0] rd_digit_q;
  logic                       mem_we;

  // Divider connections.
  logic                       div_done;
  logic [VALUE_BITS-1:0]      div_quot;
  logic [ita_pkg::DigitW-1:0] div_rem;

  // Input decode.
  ita_pkg::cmd_e              in_cmd;
  logic [VALUE_BITS-1:0]      in_raw;
  logic [VALUE_BITS-1:0]      in_sat;
  logic                       in_neg;
  logic [VALUE_BITS-1:0]      in_mag;
  logic [ita_pkg::RadixW-1:0] radix_clamped;
  logic                       out_free;

  assign in_cmd = ita_pkg::cmd_e'(s_axis_tuser);
  assign in_raw = s_axis_tdata[VALUE_BITS-1:0];
  assign in_neg = (in_cmd == ita_pkg::CMD_SIGNED) && in_raw[VALUE_BITS-1];

  // The most negative value has no positive twin, so it is nudged up by one
  // before negation.
  always_comb begin
    in_sat = in_raw;
    if (in_raw == {1'b1, {(VALUE_BITS-1){1'b0}}}) begin
      in_sat = in_raw + VALUE_BITS'(1);
    end
    in_mag = in_neg ? (~in_sat + VALUE_BITS'(1)) : in_raw;
  end

  always_comb begin
    if (radix_q < ita_pkg::RadixMin) begin
      radix_clamped = ita_pkg::RadixMin;
    end else if (radix_q > ita_pkg::RadixMax) begin
      radix_clamped = ita_pkg::RadixMax;
    end else begin
      radix_clamped = radix_q;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= ita_pkg::RadixReset;
      digits_lo_q <= '0;
      digits_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (ita_pkg::cfg_index_e'(cfg_index_i))
        ita_pkg::CFG_RADIX:       radix_q     <= cfg_data_i[ita_pkg::RadixW-1:0];
        ita_pkg::CFG_DIGITS_LOW:  digits_lo_q <= cfg_data_i;
        ita_pkg::CFG_DIGITS_HIGH: digits_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: divide repeatedly into the digit memory, then send the prefix
  // and read the digits back from the most significant one down.
  always_comb begin
    state_d     = state_q;
    remaining_d = remaining_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pre_d       = pre_q;
    neg_d       = neg_q;
    cmd_d       = cmd_q;
    base_d      = base_q;
    div_start_d = 1'b0;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && in_cmd != ita_pkg::CMD_NONE) begin
          remaining_d = in_mag;
          count_d     = '0;
          neg_d       = in_neg;
          cmd_d       = in_cmd;
          base_d      = (in_cmd == ita_pkg::CMD_SIGNED) ? radix_clamped : ita_pkg::HexRadix;
          div_start_d = 1'b1;
          state_d     = ST_DIVIDE;
        end
      end

      ST_DIVIDE: begin
        if (div_done) begin
          mem_we      = 1'b1;
          remaining_d = div_quot;
          count_d     = count_q + CntW'(1);
          if (div_quot == '0 || count_q == CntW'(Depth - 1)) begin
            ptr_d = count_q[IdxW-1:0];
            if (neg_q) begin
              pre_d   = 2'd1;
              state_d = ST_PREFIX;
            end else if (cmd_q == ita_pkg::CMD_PTR) begin
              pre_d   = 2'd2;
              state_d = ST_PREFIX;
            end else begin
              pre_d   = 2'd0;
              state_d = ST_READ;
            end
          end else begin
            div_start_d = 1'b1;
          end
        end
      end

      ST_PREFIX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b0;
          if (cmd_q == ita_pkg::CMD_PTR) begin
            out_char_d = (pre_q == 2'd2) ? ita_pkg::CharZero : ita_pkg::CharX;
          end else begin
            out_char_d = ita_pkg::CharMinus;
          end
          pre_d = pre_q - 2'd1;
          if (pre_q == 2'd1) begin
            state_d = ST_READ;
          end
        end
      end

      ST_READ: begin
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = (ptr_q == '0);
          if (cmd_q == ita_pkg::CMD_SIGNED) begin
            out_char_d = ita_pkg::table_char(rd_digit_q, digits_lo_q, digits_hi_q);
          end else begin
            out_char_d = ita_pkg::hex_char(rd_digit_q);
          end
          if (ptr_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_q - IdxW'(1);
            state_d = ST_READ;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remaining_q <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      pre_q       <= '0;
      neg_q       <= 1'b0;
      cmd_q       <= ita_pkg::CMD_SIGNED;
      base_q      <= ita_pkg::RadixReset;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      remaining_q <= remaining_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      pre_q       <= pre_d;
      neg_q       <= neg_d;
      cmd_q       <= cmd_d;
      base_q      <= base_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
  end

  // Digit memory: written with each remainder, read one entry per clock.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem_q[count_q[IdxW-1:0]] <= div_rem;
    end
    rd_digit_q <= digit_mem_q[ptr_q];
  end

  ita_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (remaining_q),
    .divisor_i  (base_q),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

endmodule
